// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assertion sampled on clk_i, disabled while rst_ni is low.
`define CLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tokenizer assertion failed");

// Assertion sampled on clk_i, also checked during reset.
`define CLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("tokenizer assertion failed");

`else

`define CLT_ASSERT(lbl, prop)
`define CLT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the command-line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clt_pkg;

  localparam int          PendW   = 6;
  localparam logic [5:0]  BsMax   = 6'd62;
  localparam logic [7:0]  ChSpace = 8'h20;
  localparam logic [7:0]  ChTab   = 8'h09;
  localparam logic [7:0]  ChBslash = 8'h5C;
  localparam logic [7:0]  ChQuote = 8'h22;
  localparam logic [7:0]  ChNul   = 8'h00;
  localparam logic [7:0]  MaxArgsRst = 8'd255;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } clt_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take input byte, plan its results, update parse state
    logic pop;   // move next planned result into the output register
  } clt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic plan_busy;  // the byte on the input makes at least one result
    logic work_last;  // the next planned result is the final one
    logic out_free;   // output register can take a result this cycle
  } clt_stat_t;

endpackage

// ----- rtl/clt_ctrl.sv -----
// ----------------------------------------------------------------------------
// clt_ctrl
// Sequencer: takes a byte, then pops its results one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clt_ctrl
  import clt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  clt_stat_t stat_i,
  output clt_cmd_t  cmd_o
);

  clt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && stat_i.plan_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free && stat_i.work_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_EMIT: begin
        cmd_o.pop = stat_i.out_free;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/clt_datapath.sv -----
// ----------------------------------------------------------------------------
// clt_datapath
// Parse state, per-byte result plan and output register of the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clt_datapath
  import clt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [7:0]  char_i,
  input  clt_cmd_t    cmd_i,
  output clt_stat_t   stat_o,
  input  logic        m_tready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        arg_done_o,
  output logic        line_done_o,
  output logic [7:0]  arg_index_o,
  output logic        last_o
);

  // parse state
  logic [7:0]       max_args_q;
  logic             in_word_q, in_word_d;
  logic             quoting_q, quoting_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [7:0]       cnt_q, cnt_d;

  // result plan of the byte in flight
  logic [PendW-1:0] bs_left_q, bs_left_d;
  logic             want_chr_q, want_chr_d;
  logic             want_ad_q, want_ad_d;
  logic             want_ld_q, want_ld_d;
  logic [7:0]       chr_q, chr_d;
  logic [7:0]       idx_q, idx_d;
  logic [7:0]       ld_idx_q, ld_idx_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q, out_idx_q;
  logic       out_bv_q, out_ad_q, out_ld_q, out_last_q;

  // plan from the input byte
  logic             is_ws, is_nul, is_bs, is_qt, start, active, eff_quot;
  logic [PendW-1:0] eff_pend, p_bs;
  logic             p_chr, p_ad, p_ld;
  logic [7:0]       p_chr_val, p_ld_idx;

  // next result
  logic [7:0] nx_byte, nx_idx;
  logic       nx_bv, nx_ad, nx_ld, nx_last;

  assign is_ws  = (char_i == ChSpace) || (char_i == ChTab);
  assign is_nul = (char_i == ChNul);
  assign is_bs  = (char_i == ChBslash);
  assign is_qt  = (char_i == ChQuote);
  assign start  = !in_word_q && !is_nul && !is_ws && (cnt_q < max_args_q);
  assign active = in_word_q || start;
  assign eff_pend = in_word_q ? pend_q : '0;
  assign eff_quot = in_word_q && quoting_q;

  always_comb begin
    p_bs      = '0;
    p_chr     = 1'b0;
    p_chr_val = char_i;
    p_ad      = 1'b0;
    p_ld      = 1'b0;
    p_ld_idx  = cnt_q;
    in_word_d = in_word_q;
    quoting_d = quoting_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    if (!active) begin
      if (is_nul) begin
        p_ld      = 1'b1;
        in_word_d = 1'b0;
        quoting_d = 1'b0;
        pend_d    = '0;
        cnt_d     = '0;
      end
    end else begin
      in_word_d = 1'b1;
      quoting_d = eff_quot;
      pend_d    = eff_pend;
      priority if (is_bs) begin
        if (eff_pend < BsMax) pend_d = eff_pend + 1'b1;
      end else if (is_qt) begin
        p_bs = eff_pend >> 1;
        if (eff_pend[0]) begin
          p_chr     = 1'b1;
          p_chr_val = ChQuote;
        end else begin
          quoting_d = !eff_quot;
        end
        pend_d = '0;
      end else if (is_nul) begin
        p_bs      = eff_pend;
        p_ad      = 1'b1;
        p_ld      = 1'b1;
        p_ld_idx  = cnt_q + 8'd1;
        in_word_d = 1'b0;
        quoting_d = 1'b0;
        pend_d    = '0;
        cnt_d     = '0;
      end else if (is_ws && !eff_quot) begin
        p_bs      = eff_pend;
        p_ad      = 1'b1;
        in_word_d = 1'b0;
        quoting_d = 1'b0;
        pend_d    = '0;
        cnt_d     = cnt_q + 8'd1;
      end else begin
        p_bs   = eff_pend;
        p_chr  = 1'b1;
        pend_d = '0;
      end
    end
  end

  // next planned result, backslashes first
  always_comb begin
    nx_byte = 8'd0;
    nx_bv   = 1'b0;
    nx_ad   = 1'b0;
    nx_ld   = 1'b0;
    nx_idx  = idx_q;
    priority if (bs_left_q != '0) begin
      nx_byte = ChBslash;
      nx_bv   = 1'b1;
    end else if (want_chr_q) begin
      nx_byte = chr_q;
      nx_bv   = 1'b1;
    end else if (want_ad_q) begin
      nx_ad = 1'b1;
    end else begin
      nx_ld  = 1'b1;
      nx_idx = ld_idx_q;
    end
  end

  assign nx_last = ((bs_left_q == PendW'(1)) && !want_chr_q && !want_ad_q && !want_ld_q) ||
                   ((bs_left_q == '0) &&
                    ({1'b0, want_chr_q} + {1'b0, want_ad_q} + {1'b0, want_ld_q} == 2'd1));

  always_comb begin
    bs_left_d  = bs_left_q;
    want_chr_d = want_chr_q;
    want_ad_d  = want_ad_q;
    want_ld_d  = want_ld_q;
    chr_d      = chr_q;
    idx_d      = idx_q;
    ld_idx_d   = ld_idx_q;
    if (cmd_i.load) begin
      bs_left_d  = p_bs;
      want_chr_d = p_chr;
      want_ad_d  = p_ad;
      want_ld_d  = p_ld;
      chr_d      = p_chr_val;
      idx_d      = cnt_q;
      ld_idx_d   = p_ld_idx;
    end else if (cmd_i.pop) begin
      priority if (bs_left_q != '0) begin
        bs_left_d = bs_left_q - 1'b1;
      end else if (want_chr_q) begin
        want_chr_d = 1'b0;
      end else if (want_ad_q) begin
        want_ad_d = 1'b0;
      end else begin
        want_ld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= MaxArgsRst;
      in_word_q  <= 1'b0;
      quoting_q  <= 1'b0;
      pend_q     <= '0;
      cnt_q      <= '0;
      bs_left_q  <= '0;
      want_chr_q <= 1'b0;
      want_ad_q  <= 1'b0;
      want_ld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) max_args_q <= cfg_data_i;
      if (cmd_i.load) begin
        in_word_q <= in_word_d;
        quoting_q <= quoting_d;
        pend_q    <= pend_d;
        cnt_q     <= cnt_d;
      end
      bs_left_q  <= bs_left_d;
      want_chr_q <= want_chr_d;
      want_ad_q  <= want_ad_d;
      want_ld_q  <= want_ld_d;
      if (cmd_i.pop) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    chr_q    <= chr_d;
    idx_q    <= idx_d;
    ld_idx_q <= ld_idx_d;
    if (cmd_i.pop) begin
      out_byte_q <= nx_byte;
      out_bv_q   <= nx_bv;
      out_ad_q   <= nx_ad;
      out_ld_q   <= nx_ld;
      out_idx_q  <= nx_idx;
      out_last_q <= nx_last;
    end
  end

  assign stat_o.plan_busy = (p_bs != '0) || p_chr || p_ad || p_ld;
  assign stat_o.work_last = nx_last;
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bv_q;
  assign arg_done_o   = out_ad_q;
  assign line_done_o  = out_ld_q;
  assign arg_index_o  = out_idx_q;
  assign last_o       = out_last_q;

endmodule

// ----- rtl/command_line_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer_core
// Splits a command-line byte stream into argument bytes and markers.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Contents
//  s_*      in   s_tvalid/s_tready    one command-line byte, 0 ends the line
//  m_*      out  m_tvalid/m_tready    one result: byte or arg/line marker
//  cfg_*    in   cfg_valid/cfg_ready  max_args write
//
//  A byte that makes no result is taken while the sequencer stays idle. A
//  byte that makes results is taken and planned, then holds the input while
//  one result per cycle moves into the output register whenever it is free.
//  The output register sets that rate; the next byte is taken while the last
//  result still waits. Reset: max_args is 255, no word open, no quoting,
//  counters cleared. An m_tready stall in ST_EMIT holds sequencer and input.
//
`timescale 1ns / 1ps

`include "assert_macros.svh"

module command_line_tokenizer_core
  import clt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte request
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_in
  // result request
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [7:0] out_byte, [15:8] arg_index
  output logic [2:0]  m_tuser_o,   // [0] byte_valid, [1] arg_done, [2] line_done
  output logic        m_tlast_o,   // last_of_run
  // configuration request
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i   // [7:0] max_args
);

  clt_cmd_t  cmd;
  clt_stat_t stat;

  logic [7:0] out_byte, arg_index;
  logic       byte_valid, arg_done, line_done;

  // config is always taken; it only changes the limit for words yet to start
  assign cfg_ready_o = 1'b1;

  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .char_i       (s_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .m_tready_i   (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .arg_done_o   (arg_done),
    .line_done_o  (line_done),
    .arg_index_o  (arg_index),
    .last_o       (m_tlast_o)
  );

  assign m_tdata_o = {arg_index, out_byte};
  assign m_tuser_o = {line_done, arg_done, byte_valid};

  // line end always closes the run of results of its byte
  `CLT_ASSERT(a_line_done_last, (m_tvalid_o && m_tuser_o[2]) |-> m_tlast_o)
  // markers never carry a byte
  `CLT_ASSERT(a_marker_no_byte, m_tvalid_o |-> !(m_tuser_o[0] && (m_tuser_o[1] || m_tuser_o[2])))
  // out_byte is zero unless byte_valid
  `CLT_ASSERT(a_zero_byte, (m_tvalid_o && !m_tuser_o[0]) |-> (m_tdata_o[7:0] == 8'd0))

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for command_line_tokenizer_core. Feeds command-line
// bytes and checks every emitted byte and marker against a cycle-free model.
// Input gaps and output stalls are random, with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import clt_pkg::*;

  // One emitted result, as the output channel carries it
  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] arg_idx;
    logic       chr_vld;
    logic       arg_end;
    logic       line_end;
    logic       run_last;
  } token_t;

  // Output-side stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_HALF,
    RX_SPARSE
  } rx_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = 8'h00;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [15:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        m_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i  = 8'h00;

  // Bytes waiting to be offered, and results still owed by the block
  logic [7:0] cmd_bytes[$];
  token_t     pending_tokens[$];

  // Tokenizer state as predicted
  logic             word_open  = 1'b0;
  logic             quote_open = 1'b0;
  logic [PendW-1:0] held_bs    = '0;
  logic [7:0]       args_done  = 8'd0;
  logic [7:0]       arg_limit  = MaxArgsRst;

  int run_len;
  int mismatches  = 0;
  int bytes_taken = 0;

  // Sender and receiver pacing
  int       burst_left = 0;
  int       gap_left   = 0;
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_mode_cnt = 0;
  int       hold_cnt   = 0;
  logic     hold_done  = 1'b0;

  command_line_tokenizer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  task automatic put_token(input logic [7:0] chr, input logic vld, input logic ad,
                           input logic ld, input logic [7:0] idx);
    token_t t;
    t.chr      = vld ? chr : ChNul;
    t.arg_idx  = idx;
    t.chr_vld  = vld;
    t.arg_end  = ad;
    t.line_end = ld;
    t.run_last = 1'b0;
    pending_tokens.push_back(t);
    run_len++;
  endtask

  task automatic emit_backslashes(input int cnt);
    int k;
    for (k = 0; k < cnt; k++) put_token(ChBslash, 1'b1, 1'b0, 1'b0, args_done);
  endtask

  task automatic clear_line();
    word_open  = 1'b0;
    quote_open = 1'b0;
    held_bs    = '0;
    args_done  = 8'd0;
  endtask

  // Works out every result that one accepted byte causes
  task automatic tokenize_byte(input logic [7:0] c);
    logic   ws;
    token_t tail;
    ws      = (c == ChSpace) || (c == ChTab);
    run_len = 0;

    // Between words: NUL closes the line, a non-blank byte may open a word
    // unless the argument limit is reached (then it is simply dropped).
    if (!word_open) begin
      if (c == ChNul) begin
        put_token(ChNul, 1'b0, 1'b0, 1'b1, args_done);
        clear_line();
      end else if (!ws && args_done < arg_limit) begin
        word_open  = 1'b1;
        quote_open = 1'b0;
        held_bs    = '0;
      end
    end

    if (word_open) begin
      if (c == ChBslash) begin
        if (held_bs < BsMax) held_bs = held_bs + 1'b1;
      end else if (c == ChQuote) begin
        // 2N backslashes: N out, quoting flips; 2N+1: N out plus a quote
        emit_backslashes(int'(held_bs >> 1));
        if (held_bs[0]) put_token(ChQuote, 1'b1, 1'b0, 1'b0, args_done);
        else quote_open = !quote_open;
        held_bs = '0;
      end else if (c == ChNul) begin
        emit_backslashes(int'(held_bs));
        put_token(ChNul, 1'b0, 1'b1, 1'b0, args_done);
        put_token(ChNul, 1'b0, 1'b0, 1'b1, args_done + 8'd1);
        clear_line();
      end else if (ws && !quote_open) begin
        emit_backslashes(int'(held_bs));
        put_token(ChNul, 1'b0, 1'b1, 1'b0, args_done);
        held_bs    = '0;
        quote_open = 1'b0;
        word_open  = 1'b0;
        args_done  = args_done + 8'd1;
      end else begin
        emit_backslashes(int'(held_bs));
        put_token(c, 1'b1, 1'b0, 1'b0, args_done);
        held_bs = '0;
      end
    end

    if (run_len != 0) begin
      tail = pending_tokens.pop_back();
      tail.run_last = 1'b1;
      pending_tokens.push_back(tail);
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predicts on accepted bytes, checks accepted results
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    token_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) arg_limit = cfg_data_i;
      if (s_tvalid_i && s_tready_o) begin
        tokenize_byte(s_tdata_i);
        bytes_taken++;
      end
      if (m_tvalid_o && m_tready_i) begin
        if (pending_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t ns: result expected none actual %h/%h/%b", $time,
                     m_tdata_o, m_tuser_o, m_tlast_o);
        end else begin
          want = pending_tokens.pop_front();
          check_field("out_byte",    want.chr,      m_tdata_o[7:0]);
          check_field("arg_index",   want.arg_idx,  m_tdata_o[15:8]);
          check_field("byte_valid",  {7'd0, want.chr_vld},  {7'd0, m_tuser_o[0]});
          check_field("arg_done",    {7'd0, want.arg_end},  {7'd0, m_tuser_o[1]});
          check_field("line_done",   {7'd0, want.line_end}, {7'd0, m_tuser_o[2]});
          check_field("last_of_run", {7'd0, want.run_last}, {7'd0, m_tlast_o});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of bytes with random gaps; a byte on offer is held
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid_i <= 1'b0;
      end else if (cmd_bytes.size() != 0) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= cmd_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall patterns; once, a long
  // hold-off lets the block back up into its input
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready_i <= 1'b0;
    end else if (!hold_done && bytes_taken >= 100) begin
      hold_done = 1'b1;
      hold_cnt  = 400;
      m_tready_i <= 1'b0;
    end else begin
      if (rx_mode_cnt == 0) begin
        rx_mode     = rx_mode_e'($urandom_range(0, 3));
        rx_mode_cnt = $urandom_range(16, 96);
      end else begin
        rx_mode_cnt--;
      end
      case (rx_mode)
        RX_OPEN:   m_tready_i <= 1'b1;
        RX_MOSTLY: m_tready_i <= ($urandom_range(0, 3) != 0);
        RX_HALF:   m_tready_i <= 1'($urandom_range(0, 1));
        default:   m_tready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1:    c = 8'($urandom_range(8'h61, 8'h7a));
      2:       c = 8'($urandom_range(1, 255));
      default: c = 8'($urandom_range(8'h80, 8'hff));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  // One line: words, backslash runs, quoted parts, noise; NUL at the end
  task automatic add_line();
    int n_tok, k, j, pick;
    n_tok = $urandom_range(1, 7);
    if ($urandom_range(0, 3) == 0) cmd_bytes.push_back(blank());
    for (k = 0; k < n_tok; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        for (j = $urandom_range(1, 5); j > 0; j--) cmd_bytes.push_back(word_char());
      end else if (pick < 60) begin
        for (j = $urandom_range(1, 4); j > 0; j--) cmd_bytes.push_back(ChBslash);
        case ($urandom_range(0, 2))
          0:       cmd_bytes.push_back(ChQuote);
          1:       cmd_bytes.push_back(word_char());
          default: ;
        endcase
      end else if (pick < 76) begin
        cmd_bytes.push_back(ChQuote);
        for (j = $urandom_range(0, 4); j > 0; j--)
          cmd_bytes.push_back($urandom_range(0, 2) == 0 ? blank() : word_char());
        // some quotes are left open
        if ($urandom_range(0, 4) != 0) cmd_bytes.push_back(ChQuote);
      end else if (pick < 78) begin
        // saturating backslash count
        for (j = $urandom_range(58, 66); j > 0; j--) cmd_bytes.push_back(ChBslash);
        cmd_bytes.push_back($urandom_range(0, 1) ? ChQuote : word_char());
      end else begin
        for (j = $urandom_range(1, 3); j > 0; j--)
          cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) != 0)
        for (j = $urandom_range(1, 2); j > 0; j--) cmd_bytes.push_back(blank());
    end
    cmd_bytes.push_back(ChNul);
  endtask

  task automatic add_lines(input int n_bytes);
    int start;
    start = cmd_bytes.size();
    while (cmd_bytes.size() - start < n_bytes) add_line();
  endtask

  // Waits until every byte is taken and every result has come, then lets the
  // block settle before a register write
  task automatic drain();
    while (cmd_bytes.size() != 0 || s_tvalid_i || pending_tokens.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_arg_limit(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stim
    int j;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, limit at reset value: empty line; blanks, extreme bytes,
    // backslash before a tab; empty quoted argument, escaped quoting, a
    // literal quote, and the line ending inside open quotes; then a word
    // left open across the next register write.
    cmd_bytes.push_back(ChNul);
    add_text(" \t");
    cmd_bytes.push_back(8'hff);
    cmd_bytes.push_back(8'h01);
    add_text("\\\t");
    cmd_bytes.push_back(ChNul);
    add_text("\"\" \\\\\"a b\\\\\\\"");
    cmd_bytes.push_back(ChNul);
    add_text("ab");
    drain();

    // Limit 1: the open word still completes, later words are dropped
    write_arg_limit(8'd1);
    add_text("c d");
    cmd_bytes.push_back(ChNul);
    add_lines(30);
    drain();

    // Limit 2, with a saturated backslash count ending the line
    write_arg_limit(8'd2);
    cmd_bytes.push_back(8'h61);
    for (j = 0; j < 64; j++) cmd_bytes.push_back(ChBslash);
    cmd_bytes.push_back(ChNul);
    add_lines(40);
    drain();

    write_arg_limit(8'd255);
    add_lines(40);
    drain();

    write_arg_limit(8'($urandom_range(3, 6)));
    add_lines(30);
    drain();

    write_arg_limit(8'($urandom_range(1, 255)));
    add_lines(25);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/clt_pkg.sv
rtl/clt_ctrl.sv
rtl/clt_datapath.sv
rtl/command_line_tokenizer_core.sv
test/testbench.sv
